FILE: src/ucb1_pkg.sv
// Shared types and constants for the UCB1 arm selector.
package ucb1_pkg;

    localparam int MAX_ARMS = 16;
    localparam int ARM_W    = 4;
    localparam int CNT_W    = 5;   // holds 1..MAX_ARMS
    localparam int VAL_W    = 32;
    localparam int DIVN_W   = 37;  // dividend width of the shared divider
    localparam int DIVD_W   = 33;  // divisor width of the shared divider
    localparam int SQIN_W   = 54;  // radicand width of the root unit
    localparam int ROOT_W   = 27;
    localparam int LOG_W    = 21;  // Q5.16 log2 of a 32-bit count
    localparam int LN_W     = 21;
    localparam int SCORE_W  = 45;
    localparam logic [15:0] LN2_Q16 = 16'd45426;

    // Configuration register indexes
    localparam logic CFG_ARMS = 1'b0;
    localparam logic CFG_GAIN = 1'b1;

    // Request codes
    localparam logic [1:0] ACT_NEXT   = 2'd0;
    localparam logic [1:0] ACT_REWARD = 2'd1;
    localparam logic [1:0] ACT_FAIL   = 2'd2;
    localparam logic [1:0] ACT_FINISH = 2'd3;

    // Per-arm record that travels around the ring of cells
    typedef struct packed {
        logic [VAL_W-1:0] mean;
        logic [VAL_W-1:0] pulls;
        logic             disc;
    } arm_t;

endpackage

FILE: src/ucb1_arm_cell.sv
// One ring cell: holds one arm record and takes its neighbor's on a shift.
module ucb1_arm_cell
    import ucb1_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic shift,
    input  arm_t arm_in,
    output arm_t arm_out
);

    arm_t arm_reg;
    arm_t arm_next;

    always_comb begin
        arm_next = shift ? arm_in : arm_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_reg <= '0;
        end else begin
            arm_reg <= arm_next;
        end
    end

    assign arm_out = arm_reg;

endmodule

FILE: src/ucb1_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module ucb1_div
    import ucb1_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVN_W-1:0] dividend,
    input  logic [DIVD_W-1:0] divisor,
    output logic              done,
    output logic [DIVN_W-1:0] quotient
);

    logic [DIVD_W-1:0] rem_reg, rem_next;
    logic [DIVN_W-1:0] quo_reg, quo_next;
    logic [DIVD_W-1:0] dvs_reg, dvs_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVD_W:0]   trial;
    logic [DIVD_W:0]   diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[DIVN_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = 6'(DIVN_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // one trial subtraction per step
            if (!diff[DIVD_W]) begin
                rem_next = diff[DIVD_W-1:0];
                quo_next = {quo_reg[DIVN_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIVD_W-1:0];
                quo_next = {quo_reg[DIVN_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: src/ucb1_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module ucb1_sqrt
    import ucb1_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SQIN_W-1:0] radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic [SQIN_W-1:0] src_reg, src_next;
    logic [30:0]       rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [30:0]       rem_sh;
    logic [30:0]       trial;

    always_comb begin
        rem_sh    = {rem_reg[28:0], src_reg[SQIN_W-1:SQIN_W-2]};
        trial     = {2'b00, root_reg, 2'b01};
        src_next  = src_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            src_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 5'(ROOT_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // bring down two radicand bits, try the next root bit
            src_next = {src_reg[SQIN_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg  <= src_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: src/ucb1_bandit_arm_selector_unit.sv
// Top level of the UCB1 bandit arm selector.
// Input channel s_*: one request carries an action code and a Q16.16 reward.
// Result channel m_*: one result per request with the arm to draw next,
// none_left when every active arm is discarded, and is_final for finish.
// Configuration: cfg_we writes cfg_data into register cfg_index at once
// (0 = arms_in_use, 1 = explore_gain); write only while the block is idle.
// The arm records sit in a ring of 16 cells that rotates one place per step.
// A request makes one update pass over the ring (plus a mean division on
// the rewarded arm) and one decision step. When no undrawn live arm exists,
// a log pass and a scoring pass follow; each live arm there takes a divider
// start, a division, a root and a compare step, any other arm a single shift.
// One request is worked on at a time; s_ready is high whenever the block is
// idle. A result waiting in the output register does not hold off the next
// request, but a stalled receiver holds the following result back until the
// register empties. Reset clears all arm records, counts and the pending
// arm, and loads arms_in_use = 16 and explore_gain = 1.0.
module ucb1_bandit_arm_selector_unit
    import ucb1_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_action,
    input  logic signed [31:0] s_reward,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ARM_W-1:0]  m_arm,
    output logic              m_none_left,
    output logic              m_is_final,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_UPD   = 4'd1;
    localparam logic [3:0] ST_UDIV  = 4'd2;
    localparam logic [3:0] ST_DEC   = 4'd3;
    localparam logic [3:0] ST_LOGN  = 4'd4;
    localparam logic [3:0] ST_LOGI  = 4'd5;
    localparam logic [3:0] ST_LNMUL = 4'd6;
    localparam logic [3:0] ST_SCORE = 4'd7;
    localparam logic [3:0] ST_SDIV  = 4'd8;
    localparam logic [3:0] ST_SSQ   = 4'd9;
    localparam logic [3:0] ST_SMUL  = 4'd10;

    // control state
    logic [3:0]         st_reg, st_next;
    logic [ARM_W-1:0]   pos_reg, pos_next;
    logic [4:0]         arms_reg, arms_next;
    logic [15:0]        gain_reg, gain_next;
    logic [VAL_W-1:0]   total_reg, total_next;
    logic [ARM_W-1:0]   pend_reg, pend_next;
    logic               pvld_reg, pvld_next;
    logic               mv_reg, mv_next;
    logic [ARM_W-1:0]   marm_reg, marm_next;
    logic               mnone_reg, mnone_next;
    logic               mfin_reg, mfin_next;
    // request and scan working state
    logic [1:0]         act_reg, act_next;
    logic [31:0]        rew_reg, rew_next;
    logic               live_reg, live_next;
    logic               und_reg, und_next;
    logic [ARM_W-1:0]   und_arm_reg, und_arm_next;
    logic [ARM_W-1:0]   most_reg, most_next;
    logic [VAL_W-1:0]   most_p_reg, most_p_next;
    logic               found_reg, found_next;
    logic [ARM_W-1:0]   pick_reg, pick_next;
    logic signed [SCORE_W-1:0] best_reg, best_next;
    logic [4:0]         msb_reg, msb_next;
    logic [31:0]        x_reg, x_next;
    logic [15:0]        frac_reg, frac_next;
    logic [4:0]         lcnt_reg, lcnt_next;
    logic [LN_W-1:0]    ln_reg, ln_next;
    logic [ROOT_W-1:0]  root_reg, root_next;

    // ring of arm cells
    arm_t cell_q [MAX_ARMS];
    arm_t head, head_new;
    logic shift;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ARMS; gi++) begin : g_ring
            arm_t nb;
            if (gi == MAX_ARMS - 1) begin : g_last
                assign nb = head_new;
            end else begin : g_mid
                assign nb = cell_q[gi+1];
            end
            ucb1_arm_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .shift   (shift),
                .arm_in  (nb),
                .arm_out (cell_q[gi])
            );
        end
    endgenerate

    assign head = cell_q[0];

    // shared divider and root unit
    logic              div_start, div_done;
    logic [DIVN_W-1:0] div_a, div_q;
    logic [DIVD_W-1:0] div_b;
    logic              sq_start, sq_done;
    logic [ROOT_W-1:0] sq_root;

    ucb1_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    ucb1_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand ({1'b0, div_q, 16'h0000}),
        .done     (sq_done),
        .root     (sq_root)
    );

    // datapath helpers
    logic [CNT_W-1:0]  n_act;
    logic              active, hit;
    logic [32:0]       diff, mag, q_s;
    logic              neg;
    logic [VAL_W-1:0]  pulls_inc, total_inc;
    logic [63:0]       sq;
    logic [4:0]        msb_enc;
    logic [LOG_W+15:0] ln_prod;
    logic [42:0]       bonus_prod;
    logic signed [SCORE_W-1:0] score;
    logic              out_free;

    always_comb begin
        if (arms_reg == 5'd0) begin
            n_act = 5'd1;
        end else if (arms_reg > 5'(MAX_ARMS)) begin
            n_act = 5'(MAX_ARMS);
        end else begin
            n_act = arms_reg;
        end
        active = {1'b0, pos_reg} < n_act;
        hit    = pvld_reg && (pos_reg == pend_reg) && active && !head.disc
                 && ((act_reg == ACT_REWARD) || (act_reg == ACT_FAIL));
        // mean update: (reward - mean) / (pulls + 1), truncated toward zero
        diff      = {rew_reg[31], rew_reg} - {head.mean[31], head.mean};
        neg       = diff[32];
        mag       = neg ? (33'd0 - diff) : diff;
        q_s       = neg ? (33'd0 - div_q[32:0]) : div_q[32:0];
        pulls_inc = (&head.pulls) ? head.pulls : head.pulls + 32'd1;
        total_inc = (&total_reg) ? total_reg : total_reg + 32'd1;
        // log2 helpers
        sq      = x_reg * x_reg;
        msb_enc = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (total_reg[i]) msb_enc = 5'(i);
        end
        ln_prod    = {msb_reg, frac_reg} * LN2_Q16;
        bonus_prod = gain_reg * root_reg;
        score      = SCORE_W'($signed(head.mean)) + $signed({2'b00, bonus_prod[42:8]});
        // result register can take a new result this cycle
        out_free   = !mv_reg || m_ready;
    end

    // divider operand select
    always_comb begin
        if (st_reg == ST_SCORE || st_reg == ST_SDIV) begin
            div_a = {ln_reg, 16'h0000};
            div_b = {1'b0, head.pulls};
        end else begin
            div_a = {4'h0, mag};
            div_b = {1'b0, head.pulls} + 33'd1;
        end
    end

    // sequencer
    always_comb begin
        st_next      = st_reg;
        pos_next     = pos_reg;
        arms_next    = arms_reg;
        gain_next    = gain_reg;
        total_next   = total_reg;
        pend_next    = pend_reg;
        pvld_next    = pvld_reg;
        mv_next      = mv_reg;
        marm_next    = marm_reg;
        mnone_next   = mnone_reg;
        mfin_next    = mfin_reg;
        act_next     = act_reg;
        rew_next     = rew_reg;
        live_next    = live_reg;
        und_next     = und_reg;
        und_arm_next = und_arm_reg;
        most_next    = most_reg;
        most_p_next  = most_p_reg;
        found_next   = found_reg;
        pick_next    = pick_reg;
        best_next    = best_reg;
        msb_next     = msb_reg;
        x_next       = x_reg;
        frac_next    = frac_reg;
        lcnt_next    = lcnt_reg;
        ln_next      = ln_reg;
        root_next    = root_reg;
        head_new     = head;
        shift        = 1'b0;
        div_start    = 1'b0;
        sq_start     = 1'b0;
        s_ready      = (st_reg == ST_IDLE);

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        if (cfg_we) begin
            if (cfg_index == CFG_ARMS) begin
                arms_next = cfg_data[4:0];
            end else begin
                gain_next = cfg_data;
            end
        end

        case (st_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    act_next    = s_action;
                    rew_next    = s_reward;
                    pos_next    = '0;
                    live_next   = 1'b0;
                    und_next    = 1'b0;
                    most_next   = '0;
                    most_p_next = '0;
                    st_next     = ST_UPD;
                end
            end
            ST_UPD, ST_UDIV: begin
                if (st_reg == ST_UPD && hit && act_reg == ACT_REWARD) begin
                    div_start = 1'b1;
                    st_next   = ST_UDIV;
                end else if (st_reg == ST_UPD || div_done) begin
                    // apply the report to the pending arm, then gather stats
                    if (hit && act_reg == ACT_REWARD) begin
                        head_new.mean  = head.mean + q_s[31:0];
                        head_new.pulls = pulls_inc;
                        total_next     = total_inc;
                    end else if (hit) begin
                        head_new.disc = 1'b1;
                    end
                    if (active) begin
                        if (!head_new.disc) live_next = 1'b1;
                        if (!head_new.disc && head_new.pulls == '0 && !und_reg) begin
                            und_next     = 1'b1;
                            und_arm_next = pos_reg;
                        end
                        if (head_new.pulls > most_p_reg) begin
                            most_next   = pos_reg;
                            most_p_next = head_new.pulls;
                        end
                    end
                    shift    = 1'b1;
                    pos_next = pos_reg + 1'b1;
                    st_next  = (pos_reg == ARM_W'(MAX_ARMS - 1)) ? ST_DEC : ST_UPD;
                end
            end
            ST_DEC: begin
                if (act_reg == ACT_FINISH) begin
                    if (out_free) begin
                        mv_next    = 1'b1;
                        marm_next  = live_reg ? most_reg : '0;
                        mnone_next = !live_reg;
                        mfin_next  = 1'b1;
                        pvld_next  = 1'b0;
                        st_next    = ST_IDLE;
                    end
                end else if (und_reg) begin
                    if (out_free) begin
                        mv_next    = 1'b1;
                        marm_next  = und_arm_reg;
                        mnone_next = 1'b0;
                        mfin_next  = 1'b0;
                        pend_next  = und_arm_reg;
                        pvld_next  = 1'b1;
                        st_next    = ST_IDLE;
                    end
                end else if (!live_reg) begin
                    if (out_free) begin
                        mv_next    = 1'b1;
                        marm_next  = '0;
                        mnone_next = 1'b1;
                        mfin_next  = 1'b0;
                        pvld_next  = 1'b0;
                        st_next    = ST_IDLE;
                    end
                end else begin
                    st_next = ST_LOGN;
                end
            end
            ST_LOGN: begin
                // normalize total so its top bit lands on bit 31
                msb_next  = msb_enc;
                x_next    = total_reg << (5'd31 - msb_enc);
                frac_next = '0;
                lcnt_next = 5'd16;
                st_next   = ST_LOGI;
            end
            ST_LOGI: begin
                // one fraction bit per squaring
                if (sq[63]) begin
                    x_next    = sq[63:32];
                    frac_next = {frac_reg[14:0], 1'b1};
                end else begin
                    x_next    = sq[62:31];
                    frac_next = {frac_reg[14:0], 1'b0};
                end
                lcnt_next = lcnt_reg - 5'd1;
                if (lcnt_reg == 5'd1) st_next = ST_LNMUL;
            end
            ST_LNMUL: begin
                ln_next    = ln_prod[LN_W+15:16];
                pos_next   = '0;
                found_next = 1'b0;
                st_next    = ST_SCORE;
            end
            ST_SCORE: begin
                if (active && !head.disc) begin
                    div_start = 1'b1;
                    st_next   = ST_SDIV;
                end else if (pos_reg != ARM_W'(MAX_ARMS - 1) || out_free) begin
                    shift    = 1'b1;
                    pos_next = pos_reg + 1'b1;
                    if (pos_reg == ARM_W'(MAX_ARMS - 1)) begin
                        mv_next    = 1'b1;
                        marm_next  = pick_reg;
                        mnone_next = 1'b0;
                        mfin_next  = 1'b0;
                        pend_next  = pick_reg;
                        pvld_next  = 1'b1;
                        st_next    = ST_IDLE;
                    end
                end
            end
            ST_SDIV: begin
                if (div_done) begin
                    sq_start = 1'b1;
                    st_next  = ST_SSQ;
                end
            end
            ST_SSQ: begin
                if (sq_done) begin
                    root_next = sq_root;
                    st_next   = ST_SMUL;
                end
            end
            ST_SMUL: begin
                // last arm waits here while the result register is full
                if (pos_reg != ARM_W'(MAX_ARMS - 1) || out_free) begin
                    // keep the first strictly better score
                    if (!found_reg || score > best_reg) begin
                        best_next  = score;
                        pick_next  = pos_reg;
                        found_next = 1'b1;
                    end
                    shift    = 1'b1;
                    pos_next = pos_reg + 1'b1;
                    if (pos_reg == ARM_W'(MAX_ARMS - 1)) begin
                        mv_next    = 1'b1;
                        mnone_next = 1'b0;
                        mfin_next  = 1'b0;
                        pvld_next  = 1'b1;
                        st_next    = ST_IDLE;
                        if (!found_reg || score > best_reg) begin
                            marm_next = pos_reg;
                            pend_next = pos_reg;
                        end else begin
                            marm_next = pick_reg;
                            pend_next = pick_reg;
                        end
                    end else begin
                        st_next = ST_SCORE;
                    end
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            pos_reg   <= '0;
            arms_reg  <= 5'(MAX_ARMS);
            gain_reg  <= 16'd256;
            total_reg <= '0;
            pend_reg  <= '0;
            pvld_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            st_reg    <= st_next;
            pos_reg   <= pos_next;
            arms_reg  <= arms_next;
            gain_reg  <= gain_next;
            total_reg <= total_next;
            pend_reg  <= pend_next;
            pvld_reg  <= pvld_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        marm_reg    <= marm_next;
        mnone_reg   <= mnone_next;
        mfin_reg    <= mfin_next;
        act_reg     <= act_next;
        rew_reg     <= rew_next;
        live_reg    <= live_next;
        und_reg     <= und_next;
        und_arm_reg <= und_arm_next;
        most_reg    <= most_next;
        most_p_reg  <= most_p_next;
        found_reg   <= found_next;
        pick_reg    <= pick_next;
        best_reg    <= best_next;
        msb_reg     <= msb_next;
        x_reg       <= x_next;
        frac_reg    <= frac_next;
        lcnt_reg    <= lcnt_next;
        ln_reg      <= ln_next;
        root_reg    <= root_next;
    end

    assign m_valid     = mv_reg;
    assign m_arm       = marm_reg;
    assign m_none_left = mnone_reg;
    assign m_is_final  = mfin_reg;

endmodule

FILE: sim/ucb1_selector_checker.sv
// Checker for the UCB1 arm selector: predicts each result and compares it.
module ucb1_selector_checker
    import ucb1_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [1:0]        s_action,
    input  logic signed [31:0] s_reward,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [ARM_W-1:0]  m_arm,
    input  logic              m_none_left,
    input  logic              m_is_final,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_data,
    output int                fail_count,
    output int                pending_results
);

    typedef struct packed {
        logic [ARM_W-1:0] arm;
        logic             none_left;
        logic             is_final;
    } pick_t;

    // predictor state
    logic [4:0]       arms_cfg;
    logic [15:0]      gain_cfg;
    logic [31:0]      mean_q  [MAX_ARMS];
    logic [31:0]      pulls_q [MAX_ARMS];
    logic             dropped [MAX_ARMS];
    logic [31:0]      total_q;
    logic [3:0]       cur_arm;
    logic             cur_valid;
    pick_t            picks_due[$];

    assign pending_results = picks_due.size();

    function automatic int live_count();
        if (arms_cfg == 0) return 1;
        if (arms_cfg > MAX_ARMS) return MAX_ARMS;
        return arms_cfg;
    endfunction

    function automatic longint unsigned log2_fix(logic [31:0] t);
        int msb;
        longint unsigned x, frac;
        msb = 0;
        frac = 0;
        if (t == 0) return 0;
        while (msb < 31 && (t >> (msb + 1)) != 0) msb++;
        x = longint'(t) << (31 - msb);
        for (int k = 0; k < 16; k++) begin
            x = (x * x) >> 31;
            frac = frac << 1;
            if (x >= (64'd1 << 32)) begin
                x = x >> 1;
                frac = frac | 1;
            end
        end
        return (longint'(msb) << 16) | frac;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint score_of(int i);
        longint unsigned ln, ratio, bonus;
        ln = (log2_fix(total_q) * LN2_Q16) >> 16;
        ratio = (ln << 16) / longint'(pulls_q[i]);
        bonus = (longint'(gain_cfg) * root_floor(ratio << 16)) >> 8;
        return longint'($signed(mean_q[i])) + longint'(bonus);
    endfunction

    // next-arm choice: undrawn live arm first, else best score
    function automatic bit choose(output logic [3:0] sel);
        int n;
        bit found;
        longint best, s;
        n = live_count();
        found = 0;
        best = 0;
        sel = 0;
        for (int i = 0; i < n; i++)
            if (!dropped[i] && pulls_q[i] == 0) begin
                sel = 4'(i);
                return 1;
            end
        for (int i = 0; i < n; i++) begin
            if (dropped[i]) continue;
            s = score_of(i);
            if (!found || s > best) begin
                best = s;
                sel = 4'(i);
                found = 1;
            end
        end
        return found;
    endfunction

    function automatic pick_t apply_request(logic [1:0] act, logic signed [31:0] rew);
        pick_t res;
        int n, top;
        bit live, ok;
        logic [3:0] sel;
        longint m, d;
        n = live_count();
        ok = cur_valid && cur_arm < n && !dropped[cur_arm];
        if (act == ACT_FINISH) begin
            live = 0;
            top = 0;
            for (int i = 0; i < n; i++) begin
                if (!dropped[i]) live = 1;
                if (pulls_q[i] > pulls_q[top]) top = i;
            end
            cur_valid = 0;
            res.arm = live ? top[3:0] : '0;
            res.none_left = !live;
            res.is_final = 1;
            return res;
        end
        if (act == ACT_REWARD && ok) begin
            m = longint'($signed(mean_q[cur_arm]));
            d = longint'(pulls_q[cur_arm]) + 1;
            m = m + (longint'(rew) - m) / d;
            mean_q[cur_arm] = m[31:0];
            if (pulls_q[cur_arm] != '1) pulls_q[cur_arm]++;
            if (total_q != '1) total_q++;
        end else if (act == ACT_FAIL && ok) begin
            dropped[cur_arm] = 1;
        end
        live = choose(sel);
        cur_valid = live;
        if (live) cur_arm = sel;
        res.arm = live ? sel : '0;
        res.none_left = !live;
        res.is_final = 0;
        return res;
    endfunction

    always @(posedge aclk) begin
        pick_t want;
        if (!aresetn) begin
            arms_cfg <= 5'd16;
            gain_cfg <= 16'd256;
            for (int i = 0; i < MAX_ARMS; i++) begin
                mean_q[i] = '0;
                pulls_q[i] = '0;
                dropped[i] = 0;
            end
            total_q = '0;
            cur_arm = '0;
            cur_valid = 0;
            picks_due.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_ARMS) arms_cfg <= cfg_data[4:0];
                else arms_cfg <= arms_cfg;
                if (cfg_index == CFG_GAIN) gain_cfg <= cfg_data;
            end
            if (s_valid && s_ready)
                picks_due.insert(picks_due.size(), apply_request(s_action, s_reward));
            // compare accepted result with oldest prediction
            if (m_valid && m_ready) begin
                if (picks_due.size() == 0) begin
                    $error("unexpected result arm=%0d", m_arm);
                    fail_count <= fail_count + 1;
                end else begin
                    want = picks_due.pop_front();
                    if (m_arm !== want.arm) $error("arm exp %0d got %0d", want.arm, m_arm);
                    if (m_none_left !== want.none_left)
                        $error("none_left exp %0d got %0d", want.none_left, m_none_left);
                    if (m_is_final !== want.is_final)
                        $error("is_final exp %0d got %0d", want.is_final, m_is_final);
                    if (m_arm !== want.arm || m_none_left !== want.none_left ||
                        m_is_final !== want.is_final)
                        fail_count <= fail_count + 1;
                end
            end
        end
    end

endmodule

FILE: sim/tb_ucb1_bandit_arm_selector_unit.sv
// Testbench top for the UCB1 arm selector: stimulus, stalls and verdict.
module tb_ucb1_bandit_arm_selector_unit;
    import ucb1_pkg::*;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_action;
    logic signed [31:0] s_reward;
    logic              m_valid;
    logic              m_ready;
    logic [ARM_W-1:0]  m_arm;
    logic              m_none_left;
    logic              m_is_final;
    logic              cfg_we;
    logic              cfg_index;
    logic [15:0]       cfg_data;
    int                fail_count;
    int                pending_results;
    int                cycle_count;
    bit                hold_off;

    localparam int CYCLE_LIMIT = 3_000_000;

    ucb1_bandit_arm_selector_unit dut (.*);
    ucb1_selector_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // receiver stall pattern, plus one long hold-off
    initial begin
        m_ready = 0;
        forever begin
            @(posedge aclk);
            if (hold_off) m_ready <= 0;
            else if (cycle_count % 400 < 150) m_ready <= 1;
            else m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // valid stays high after the accept; the caller drops it
    task automatic send_request(logic [1:0] act, logic [31:0] rew);
        s_valid <= 1;
        s_action <= act;
        s_reward <= rew;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic random_gap();
        if ($urandom_range(0, 3) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 0;
        @(posedge aclk);
    endtask

    task automatic drain();
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // mostly reward reports on the proposed arm, some failures, next requests and finishes
    task automatic random_phase(int count);
        int k;
        logic [1:0] act;
        logic [31:0] rew;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(0, 19))
                0: act = ACT_FINISH;
                1, 2: act = ACT_FAIL;
                3, 4: act = ACT_NEXT;
                default: act = ACT_REWARD;
            endcase
            rew = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 131072) - 32768;
            send_request(act, rew);
            random_gap();
        end
        s_valid <= 0;
    endtask

    initial begin
        aresetn = 0;
        s_valid = 0;
        s_action = ACT_NEXT;
        s_reward = 0;
        cfg_we = 0;
        cfg_index = CFG_ARMS;
        cfg_data = 0;
        hold_off = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: reports with nothing pending, extremes, every action
        send_request(ACT_REWARD, 32'h7fffffff);
        send_request(ACT_FAIL, 32'h0);
        send_request(ACT_FINISH, 32'h0);
        send_request(ACT_REWARD, 32'h7fffffff);
        send_request(ACT_REWARD, 32'h80000000);
        send_request(ACT_NEXT, 32'hffffffff);
        send_request(ACT_FAIL, 32'h0);
        send_request(ACT_REWARD, 32'h00010000);
        send_request(ACT_FINISH, 32'h0);
        s_valid <= 0;
        drain();
        // one arm: discard it, then no live arm
        write_reg(CFG_ARMS, 16'd1);
        write_reg(CFG_GAIN, 16'hffff);
        send_request(ACT_NEXT, 0);
        send_request(ACT_REWARD, 32'h80000000);
        send_request(ACT_REWARD, 32'h7fffffff);
        send_request(ACT_FAIL, 0);
        send_request(ACT_NEXT, 0);
        send_request(ACT_FINISH, 0);
        s_valid <= 0;
        drain();
        // out-of-range arm counts and gain extremes
        write_reg(CFG_ARMS, 16'd0);
        write_reg(CFG_GAIN, 16'd0);
        send_request(ACT_NEXT, 0);
        send_request(ACT_REWARD, 32'h1234);
        s_valid <= 0;
        drain();
        write_reg(CFG_ARMS, 16'd31);
        write_reg(CFG_GAIN, 16'hffff);

        // long hold-off so the block fills and stalls its input
        hold_off = 1;
        fork
            random_phase(10);
            begin
                repeat (3000) @(posedge aclk);
                hold_off = 0;
            end
        join
        drain();

        write_reg(CFG_ARMS, 16'd3);
        write_reg(CFG_GAIN, 16'd256);
        random_phase(200);
        drain();
        write_reg(CFG_ARMS, 16'd2);
        write_reg(CFG_GAIN, 16'd5000);
        random_phase(200);
        drain();
        write_reg(CFG_ARMS, 16'd16);
        write_reg(CFG_GAIN, 16'd1);
        random_phase(150);

        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
